// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the pulse train block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_ALWAYS(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

// ===== design/ptp_pkg.sv =====
// Types and constants of the pulse train generator with preamble.
`default_nettype none

package ptp_pkg;

  // Tick time arithmetic wraps at 2**TIME_W
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned COUNT_W   = 15;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Periods at or above this length force the wake-up preamble
  localparam logic [TIME_W-1:0] SLEEP_PERIOD_TICKS    = 16'd300;
  localparam logic [TIME_W-1:0] WAKEUP_PREAMBLE_TICKS = 16'd5;

  // Register reset values
  localparam logic [COUNT_W-1:0] PULSE_COUNT_RST    = 15'd1;
  localparam logic [TIME_W-1:0]  HIGH_TICKS_RST     = 16'd1;
  localparam logic [TIME_W-1:0]  PERIOD_TICKS_RST   = 16'd10;
  localparam logic [TIME_W-1:0]  PREAMBLE_TICKS_RST = 16'd0;

  // Command codes; the unused code acts as no command
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_TICKS = 2'd3;

  typedef enum logic [1:0] {
    PH_STANDBY  = 2'd0,
    PH_PREAMBLE = 2'd1,
    PH_HIGH     = 2'd2,
    PH_LOW      = 2'd3
  } phase_t;

  // A target counts as reached when now lies in the half circle after it
  function automatic logic time_reached(input logic [TIME_W-1:0] now,
                                        input logic [TIME_W-1:0] target);
    logic [TIME_W-1:0] diff;
    diff = now - target;
    return ~diff[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

// ===== design/ptp_ifs.sv =====
// Valid/ready channel interfaces for commands in and pin levels out.
`default_nettype none

interface ptp_in_if;
  logic                         valid;
  logic                         ready;
  logic [ptp_pkg::CMD_W-1:0]    req_type;
  logic [ptp_pkg::TIME_W-1:0]   time_now;

  modport source (output valid, output req_type, output time_now, input ready);
  modport sink   (input valid, input req_type, input time_now, output ready);
endinterface

interface ptp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         main_level;
  logic                         sub_level;
  logic [ptp_pkg::COUNT_W-1:0]  pulses_left;

  modport source (output valid, output main_level, output sub_level,
                  output pulses_left, input ready);
  modport sink   (input valid, input main_level, input sub_level,
                  input pulses_left, output ready);
endinterface

`default_nettype wire

// ===== design/pulse_train_with_preamble_top.sv =====
// Top level of the pulse train generator with preamble.
//
//   channel   dir  payload                               beat
//   in_ch     in   req_type[1:0], time_now[15:0]         one command per tick sample
//   out_ch    out  main_level, sub_level, pulses_left    one result per input beat
//   cfg_*     in   cfg_index[1:0], cfg_wdata[15:0]       write on cfg_wr_en
//
// Each input beat is processed as it is accepted: the phase machine updates its
// state and the result lands in the output register on the accepting edge.
// One beat per cycle is sustained; a stalled output beat blocks input only
// while the output register is full and not being drained in that cycle.
// Synchronous active-low reset returns to standby with the default registers.
`default_nettype none
`include "assert_macros.svh"

module pulse_train_with_preamble_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ptp_in_if.sink                                 in_ch,
  ptp_out_if.source                              out_ch,
  input  wire logic                              cfg_wr_en,
  input  wire logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ptp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned TW = ptp_pkg::TIME_W;
  localparam int unsigned CW = ptp_pkg::COUNT_W;

  // Configuration registers
  logic [CW-1:0] pulse_count_r;
  logic [TW-1:0] high_ticks_r;
  logic [TW-1:0] period_ticks_r;
  logic [TW-1:0] preamble_ticks_r;

  // Phase machine state
  ptp_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] remaining_r, remaining_nxt;
  logic [TW-1:0] period_origin_r, period_origin_nxt;
  logic [TW-1:0] high_start_r, high_start_nxt;

  // Output register
  logic          out_valid_r;
  logic          main_level_r, main_level_nxt;
  logic          sub_level_r, sub_level_nxt;
  logic [CW-1:0] pulses_left_r;

  logic          in_fire;
  logic          rst_cmd;
  logic          run_load;
  logic [TW-1:0] pre_len;
  logic [TW-1:0] pre_end;
  logic [TW-1:0] high_end;
  logic [TW-1:0] now;
  logic [ptp_pkg::CMD_W-1:0] cmd;

  // Handshake: take a beat whenever the output register is free or draining
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;
  assign cmd         = in_ch.req_type;
  assign now         = in_ch.time_now;

  // Command decode
  assign rst_cmd  = (cmd == ptp_pkg::CMD_RESET);
  assign run_load = (phase_r == ptp_pkg::PH_STANDBY) && (cmd == ptp_pkg::CMD_RUN);

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r    <= ptp_pkg::PULSE_COUNT_RST;
      high_ticks_r     <= ptp_pkg::HIGH_TICKS_RST;
      period_ticks_r   <= ptp_pkg::PERIOD_TICKS_RST;
      preamble_ticks_r <= ptp_pkg::PREAMBLE_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptp_pkg::CFG_PULSE_COUNT:    pulse_count_r    <= cfg_wdata[CW-1:0];
        ptp_pkg::CFG_HIGH_TICKS:     high_ticks_r     <= cfg_wdata[TW-1:0];
        ptp_pkg::CFG_PERIOD_TICKS:   period_ticks_r   <= cfg_wdata[TW-1:0];
        ptp_pkg::CFG_PREAMBLE_TICKS: preamble_ticks_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Preamble length and phase end times
  assign pre_len  = (period_ticks_r >= ptp_pkg::SLEEP_PERIOD_TICKS)
                    ? ptp_pkg::WAKEUP_PREAMBLE_TICKS : preamble_ticks_r;
  assign pre_end  = period_origin_r + pre_len;
  assign high_end = high_start_r + high_ticks_r;

  // Next state
  always_comb begin
    phase_nxt         = phase_r;
    remaining_nxt     = remaining_r;
    period_origin_nxt = period_origin_r;
    high_start_nxt    = high_start_r;
    case (phase_r)
      ptp_pkg::PH_PREAMBLE: begin
        high_start_nxt = pre_end;
        if (rst_cmd) begin
          phase_nxt = ptp_pkg::PH_STANDBY;
        end else if (ptp_pkg::time_reached(now, pre_end)) begin
          phase_nxt = ptp_pkg::PH_HIGH;
        end
      end
      ptp_pkg::PH_HIGH: begin
        if (rst_cmd) begin
          phase_nxt = ptp_pkg::PH_STANDBY;
        end else if (ptp_pkg::time_reached(now, high_end)) begin
          phase_nxt         = ptp_pkg::PH_LOW;
          period_origin_nxt = period_origin_r + period_ticks_r;
          if (remaining_r != '0) begin
            remaining_nxt = remaining_r - CW'(1);
          end
        end
      end
      ptp_pkg::PH_LOW: begin
        if (rst_cmd || remaining_r == '0) begin
          phase_nxt = ptp_pkg::PH_STANDBY;
        end else if (ptp_pkg::time_reached(now, period_origin_r)) begin
          phase_nxt = ptp_pkg::PH_PREAMBLE;
        end
      end
      default: begin
        if (run_load) begin
          phase_nxt         = ptp_pkg::PH_PREAMBLE;
          remaining_nxt     = pulse_count_r;
          period_origin_nxt = now;
          high_start_nxt    = now + pre_len;
        end
      end
    endcase
  end

  // Pin levels follow the phase held at the start of the beat; a reset command drives both low
  always_comb begin
    main_level_nxt = 1'b0;
    sub_level_nxt  = 1'b0;
    case (phase_r)
      ptp_pkg::PH_PREAMBLE: begin
        sub_level_nxt = ~rst_cmd;
      end
      ptp_pkg::PH_HIGH: begin
        main_level_nxt = ~rst_cmd;
        sub_level_nxt  = ~rst_cmd;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= ptp_pkg::PH_STANDBY;
      remaining_r     <= '0;
      period_origin_r <= '0;
      high_start_r    <= '0;
    end else if (in_fire) begin
      phase_r         <= phase_nxt;
      remaining_r     <= remaining_nxt;
      period_origin_r <= period_origin_nxt;
      high_start_r    <= high_start_nxt;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      main_level_r  <= main_level_nxt;
      sub_level_r   <= sub_level_nxt;
      pulses_left_r <= remaining_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.main_level  = main_level_r;
  assign out_ch.sub_level   = sub_level_r;
  assign out_ch.pulses_left = pulses_left_r;

  // Checks
  `ASSERT_ALWAYS(a_reset_idle, clk, rst_n, in_fire && rst_cmd |=> phase_r == ptp_pkg::PH_STANDBY)
  `ASSERT_NEVER(a_main_without_sub, clk, rst_n, out_valid_r && main_level_r && !sub_level_r)
  `ASSERT_ALWAYS(a_no_reload, clk, rst_n, !run_load |=> remaining_r <= $past(remaining_r))
  `ASSERT_ALWAYS(a_beat_lands, clk, rst_n, in_fire |=> out_valid_r && pulses_left_r == remaining_r)

endmodule

`default_nettype wire
